// ===== hdl/amd_pkg.sv =====
`timescale 1ns / 1ps

package amd_pkg;

	// Q16.16 word
	localparam int XW = 32;

	// pipelined square root: 64-bit radicand, 32-bit root, one result bit per stage
	localparam int SQ_IN_W  = 64;
	localparam int SQ_OUT_W = 32;
	localparam int SQ_LAT   = SQ_OUT_W;

	// pipelined restoring divider: one quotient bit per stage
	localparam int DV_NUM_W = 64;
	localparam int DV_DEN_W = 32;
	localparam int DV_Q_W   = 31;
	localparam int DV_LAT   = DV_Q_W;

endpackage

// ===== hdl/affine_matrix_decompose.sv =====
`timescale 1ns / 1ps

// Affine matrix decomposition: translation, per-axis scale, rotation quaternion.
//
// Input channel: one matrix word (three basis columns plus translation,
// all Q16.16) is taken at each rising edge where start is high and busy is
// low. busy is always low, so a new word may enter on every cycle.
// Output channel: done pulses for one cycle with pos, scale, quat and
// degenerate valid on the same cycle. There is no back-pressure; the
// receiver must take each word when it appears.
// Throughput: one word per cycle. The path from accept to done is set by
// two 32-stage square roots (column length and quaternion root) and two
// 31-stage restoring dividers (normalization and off-axis components),
// each retiring one bit per stage.
// Reset: arst_n clears every valid bit at once; words in flight are dropped
// and no done pulse appears until a new word has gone through.
// A zero-length column raises degenerate and gives the identity quaternion.
module affine_matrix_decompose (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] col0_x,
	input  logic signed [31:0] col0_y,
	input  logic signed [31:0] col0_z,
	input  logic signed [31:0] col1_x,
	input  logic signed [31:0] col1_y,
	input  logic signed [31:0] col1_z,
	input  logic signed [31:0] col2_x,
	input  logic signed [31:0] col2_y,
	input  logic signed [31:0] col2_z,
	input  logic signed [31:0] trans_x,
	input  logic signed [31:0] trans_y,
	input  logic signed [31:0] trans_z,
	output logic               done,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic        [30:0] scale_x,
	output logic        [30:0] scale_y,
	output logic        [30:0] scale_z,
	output logic signed [17:0] quat_x,
	output logic signed [17:0] quat_y,
	output logic signed [17:0] quat_z,
	output logic signed [17:0] quat_w,
	output logic               degenerate
);
	import amd_pkg::*;

	localparam int LAT = 2 + SQ_LAT + DV_LAT + 3 + SQ_LAT + 1 + DV_LAT + 1;
	localparam logic [16:0]        ONE_Q16 = 17'd65536;
	localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

	typedef logic [1:0] axis_t;
	localparam axis_t AX_X = 2'd0;
	localparam axis_t AX_Y = 2'd1;
	localparam axis_t AX_Z = 2'd2;

	// cyclic successor of an axis
	function automatic axis_t nxt_ax(input axis_t a);
		axis_t r;
		case (a)
			AX_X:    r = AX_Y;
			AX_Y:    r = AX_Z;
			default: r = AX_X;
		endcase
		return r;
	endfunction

	// sideband across the column-length root
	typedef struct packed {
		logic [2:0][2:0]         neg;
		logic [2:0][2:0][XW-1:0] mag;
		logic [2:0][XW-1:0]      trans;
	} sb1_t;

	// sideband across the normalizing dividers
	typedef struct packed {
		logic [2:0][2:0]    neg;
		logic               degen;
		logic [2:0][30:0]   scale;
		logic [2:0][XW-1:0] trans;
	} sb2_t;

	// sideband across the quaternion root
	typedef struct packed {
		logic [2:0][31:0]   dmag;
		logic [2:0]         dneg;
		logic               tflag;
		axis_t              ax;
		logic               degen;
		logic [2:0][30:0]   scale;
		logic [2:0][XW-1:0] trans;
	} sb3_t;

	// sideband across the component dividers
	typedef struct packed {
		logic [2:0]         ovf;
		logic [2:0]         dneg;
		logic [16:0]        main;
		logic               tflag;
		axis_t              ax;
		logic               degen;
		logic [2:0][30:0]   scale;
		logic [2:0][XW-1:0] trans;
	} sb4_t;

	assign busy = 1'b0;

	// ---------------- stage 1: magnitudes and squares ----------------
	logic [2:0][2:0][XW-1:0] c_in;
	logic [2:0][2:0][XW-1:0] mag_in;

	assign c_in[0][0] = col0_x;
	assign c_in[0][1] = col0_y;
	assign c_in[0][2] = col0_z;
	assign c_in[1][0] = col1_x;
	assign c_in[1][1] = col1_y;
	assign c_in[1][2] = col1_z;
	assign c_in[2][0] = col2_x;
	assign c_in[2][1] = col2_y;
	assign c_in[2][2] = col2_z;

	always_comb begin
		for (int a = 0; a < 3; a++)
			for (int b = 0; b < 3; b++)
				mag_in[a][b] = c_in[a][b][XW-1] ? (~c_in[a][b] + 1'b1) : c_in[a][b];
	end

	logic                       v_s1;
	logic [2:0][2:0]            neg_s1;
	logic [2:0][2:0][XW-1:0]    mag_s1;
	logic [2:0][2:0][2*XW-1:0]  sq_s1;
	logic [2:0][XW-1:0]         trans_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				neg_s1[a][b] <= c_in[a][b][XW-1];
				mag_s1[a][b] <= mag_in[a][b];
				sq_s1[a][b]  <= (2*XW)'(mag_in[a][b]) * (2*XW)'(mag_in[a][b]);
			end
		end
		trans_s1[0] <= trans_x;
		trans_s1[1] <= trans_y;
		trans_s1[2] <= trans_z;
	end

	// ---------------- stage 2: sums of squares ----------------
	logic                      v_s2;
	logic [2:0][2*XW-1:0]      sum_s2;
	sb1_t                      sb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++)
			sum_s2[a] <= sq_s1[a][0] + sq_s1[a][1] + sq_s1[a][2];
		sb_s2.neg   <= neg_s1;
		sb_s2.mag   <= mag_s1;
		sb_s2.trans <= trans_s1;
	end

	// ---------------- column lengths ----------------
	logic                     len_v;
	logic [2:0][SQ_OUT_W-1:0] len;
	sb1_t                     sb1_s [SQ_LAT];

	for (genvar a = 0; a < 3; a++) begin : g_len
		if (a == 0) begin : g_v
			amd_sqrt u_sqrt (
				.clk    (clk),
				.arst_n (arst_n),
				.vin    (v_s2),
				.rad    (sum_s2[a]),
				.vout   (len_v),
				.root   (len[a])
			);
		end else begin : g_nv
			amd_sqrt u_sqrt (
				.clk    (clk),
				.arst_n (arst_n),
				.vin    (v_s2),
				.rad    (sum_s2[a]),
				.vout   (),
				.root   (len[a])
			);
		end
	end

	always_ff @(posedge clk) begin
		sb1_s[0] <= sb_s2;
		for (int t = 1; t < SQ_LAT; t++)
			sb1_s[t] <= sb1_s[t-1];
	end

	// ---------------- normalization ----------------
	sb1_t sb1_o;
	sb2_t sb2_in;

	assign sb1_o = sb1_s[SQ_LAT-1];

	always_comb begin
		sb2_in.neg   = sb1_o.neg;
		sb2_in.trans = sb1_o.trans;
		sb2_in.degen = (len[0] == '0) || (len[1] == '0) || (len[2] == '0);
		for (int a = 0; a < 3; a++)
			sb2_in.scale[a] = len[a][SQ_OUT_W-1] ? {31{1'b1}} : len[a][30:0];
	end

	logic                          nrm_v;
	logic [2:0][2:0][DV_Q_W-1:0]   nq;
	sb2_t                          sb2_s [DV_LAT];

	for (genvar a = 0; a < 3; a++) begin : g_nrm_a
		for (genvar b = 0; b < 3; b++) begin : g_nrm_b
			if (a == 0 && b == 0) begin : g_v
				amd_div u_div (
					.clk    (clk),
					.arst_n (arst_n),
					.vin    (len_v),
					.num    ({2'b00, sb1_o.mag[a][b], 30'd0}),
					.den    (len[a]),
					.vout   (nrm_v),
					.quo    (nq[a][b])
				);
			end else begin : g_nv
				amd_div u_div (
					.clk    (clk),
					.arst_n (arst_n),
					.vin    (len_v),
					.num    ({2'b00, sb1_o.mag[a][b], 30'd0}),
					.den    (len[a]),
					.vout   (),
					.quo    (nq[a][b])
				);
			end
		end
	end

	always_ff @(posedge clk) begin
		sb2_s[0] <= sb2_in;
		for (int t = 1; t < DV_LAT; t++)
			sb2_s[t] <= sb2_s[t-1];
	end

	// ---------------- stage 4: signed normalized entries (Q30) ----------------
	sb2_t sb2_o;
	assign sb2_o = sb2_s[DV_LAT-1];

	logic                  v_s4;
	logic signed [XW-1:0]  n_s4 [3][3];
	logic                  degen_s4;
	logic [2:0][30:0]      scale_s4;
	logic [2:0][XW-1:0]    trans_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= nrm_v;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++)
			for (int b = 0; b < 3; b++)
				n_s4[a][b] <= sb2_o.neg[a][b] ? -$signed({1'b0, nq[a][b]})
				                              :  $signed({1'b0, nq[a][b]});
		degen_s4 <= sb2_o.degen;
		scale_s4 <= sb2_o.scale;
		trans_s4 <= sb2_o.trans;
	end

	// ---------------- stage 5: trace and major axis ----------------
	axis_t i_sel;

	always_comb begin
		i_sel = AX_X;
		if (n_s4[1][1] > n_s4[0][0])
			i_sel = AX_Y;
		if (n_s4[2][2] > ((i_sel == AX_Y) ? n_s4[1][1] : n_s4[0][0]))
			i_sel = AX_Z;
	end

	logic                  v_s5;
	logic signed [32:0]    trace_s5;
	axis_t                 i_s5;
	logic signed [XW-1:0]  n_s5 [3][3];
	logic                  degen_s5;
	logic [2:0][30:0]      scale_s5;
	logic [2:0][XW-1:0]    trans_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		trace_s5 <= 33'(n_s4[0][0]) + 33'(n_s4[1][1]) + 33'(n_s4[2][2]);
		i_s5     <= i_sel;
		n_s5     <= n_s4;
		degen_s5 <= degen_s4;
		scale_s5 <= scale_s4;
		trans_s5 <= trans_s4;
	end

	// ---------------- stage 6: root argument and numerators ----------------
	axis_t              j5, k5;
	logic               tpos;
	logic signed [33:0] arg;
	logic signed [32:0] d5 [3];

	always_comb begin
		j5   = nxt_ax(i_s5);
		k5   = nxt_ax(j5);
		tpos = (trace_s5 > 33'sd0);
		if (tpos) begin
			arg   = 34'(trace_s5) + ONE_Q30;
			d5[0] = 33'(n_s5[1][2]) - 33'(n_s5[2][1]);
			d5[1] = 33'(n_s5[2][0]) - 33'(n_s5[0][2]);
			d5[2] = 33'(n_s5[0][1]) - 33'(n_s5[1][0]);
		end else begin
			arg   = 34'(n_s5[i_s5][i_s5]) - 34'(n_s5[j5][j5]) - 34'(n_s5[k5][k5]) + ONE_Q30;
			d5[0] = 33'(n_s5[i_s5][j5]) + 33'(n_s5[j5][i_s5]);
			d5[1] = 33'(n_s5[i_s5][k5]) + 33'(n_s5[k5][i_s5]);
			d5[2] = 33'(n_s5[j5][k5]) - 33'(n_s5[k5][j5]);
		end
	end

	logic                v_s6;
	logic [SQ_IN_W-1:0]  rad_s6;
	sb3_t                sb_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		// non-positive argument gives a zero root, forced to one LSB later
		rad_s6 <= (arg > 34'sd0) ? {arg[33:0], 30'd0} : '0;
		for (int s = 0; s < 3; s++) begin
			sb_s6.dneg[s] <= d5[s][32];
			sb_s6.dmag[s] <= d5[s][32] ? 32'(-d5[s]) : 32'(d5[s]);
		end
		sb_s6.tflag <= tpos;
		sb_s6.ax    <= i_s5;
		sb_s6.degen <= degen_s5;
		sb_s6.scale <= scale_s5;
		sb_s6.trans <= trans_s5;
	end

	// ---------------- quaternion root ----------------
	logic                rt_v;
	logic [SQ_OUT_W-1:0] rt;
	sb3_t                sb3_s [SQ_LAT];

	amd_sqrt u_qroot (
		.clk    (clk),
		.arst_n (arst_n),
		.vin    (v_s6),
		.rad    (rad_s6),
		.vout   (rt_v),
		.root   (rt)
	);

	always_ff @(posedge clk) begin
		sb3_s[0] <= sb_s6;
		for (int t = 1; t < SQ_LAT; t++)
			sb3_s[t] <= sb3_s[t-1];
	end

	// ---------------- stage 7: root fix, overflow check, main component ----------------
	sb3_t                sb3_o;
	logic [SQ_OUT_W-1:0] rt_fix;

	assign sb3_o  = sb3_s[SQ_LAT-1];
	assign rt_fix = (rt == '0) ? {{(SQ_OUT_W-1){1'b0}}, 1'b1} : rt;

	logic                 v_s7;
	logic [SQ_OUT_W-1:0]  root_s7;
	logic [2:0][31:0]     dmag_s7;
	sb4_t                 sb_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= rt_v;
		end
	end

	always_ff @(posedge clk) begin
		root_s7 <= rt_fix;
		dmag_s7 <= sb3_o.dmag;
		// quotient of at least 2^17 saturates anyway
		for (int s = 0; s < 3; s++)
			sb_s7.ovf[s] <= ({2'b00, sb3_o.dmag[s]} >= {rt_fix, 2'b00});
		sb_s7.dneg  <= sb3_o.dneg;
		sb_s7.main  <= (rt_fix[31:15] > ONE_Q16) ? ONE_Q16 : rt_fix[31:15];
		sb_s7.tflag <= sb3_o.tflag;
		sb_s7.ax    <= sb3_o.ax;
		sb_s7.degen <= sb3_o.degen;
		sb_s7.scale <= sb3_o.scale;
		sb_s7.trans <= sb3_o.trans;
	end

	// ---------------- off-axis components ----------------
	logic                    cmp_v;
	logic [2:0][DV_Q_W-1:0]  cq;
	sb4_t                    sb4_s [DV_LAT];

	for (genvar s = 0; s < 3; s++) begin : g_cmp
		if (s == 0) begin : g_v
			amd_div u_div (
				.clk    (clk),
				.arst_n (arst_n),
				.vin    (v_s7),
				.num    ({17'd0, dmag_s7[s], 15'd0}),
				.den    (root_s7),
				.vout   (cmp_v),
				.quo    (cq[s])
			);
		end else begin : g_nv
			amd_div u_div (
				.clk    (clk),
				.arst_n (arst_n),
				.vin    (v_s7),
				.num    ({17'd0, dmag_s7[s], 15'd0}),
				.den    (root_s7),
				.vout   (),
				.quo    (cq[s])
			);
		end
	end

	always_ff @(posedge clk) begin
		sb4_s[0] <= sb_s7;
		for (int t = 1; t < DV_LAT; t++)
			sb4_s[t] <= sb4_s[t-1];
	end

	// ---------------- output stage ----------------
	sb4_t               sb4_o;
	logic [16:0]        cm [3];
	logic signed [17:0] cv [3];
	logic signed [17:0] mv;
	logic signed [17:0] qv [4];
	axis_t              jo, ko;

	assign sb4_o = sb4_s[DV_LAT-1];

	always_comb begin
		for (int s = 0; s < 3; s++) begin
			if (sb4_o.ovf[s] || (cq[s][16:0] > ONE_Q16))
				cm[s] = ONE_Q16;
			else
				cm[s] = cq[s][16:0];
			cv[s] = sb4_o.dneg[s] ? -$signed({1'b0, cm[s]}) : $signed({1'b0, cm[s]});
		end
		mv = $signed({1'b0, sb4_o.main});
		jo = nxt_ax(sb4_o.ax);
		ko = nxt_ax(jo);
		for (int s = 0; s < 4; s++)
			qv[s] = '0;
		if (sb4_o.degen) begin
			qv[3] = $signed({1'b0, ONE_Q16});
		end else if (sb4_o.tflag) begin
			qv[0] = cv[0];
			qv[1] = cv[1];
			qv[2] = cv[2];
			qv[3] = mv;
		end else begin
			qv[sb4_o.ax] = mv;
			qv[jo]       = cv[0];
			qv[ko]       = cv[1];
			qv[3]        = cv[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmp_v;
		end
	end

	always_ff @(posedge clk) begin
		pos_x      <= sb4_o.trans[0];
		pos_y      <= sb4_o.trans[1];
		pos_z      <= sb4_o.trans[2];
		scale_x    <= sb4_o.scale[0];
		scale_y    <= sb4_o.scale[1];
		scale_z    <= sb4_o.scale[2];
		quat_x     <= qv[0];
		quat_y     <= qv[1];
		quat_z     <= qv[2];
		quat_w     <= qv[3];
		degenerate <= sb4_o.degen;
	end

`ifndef SYNTHESIS
	// every result word traces back to an accepted word a fixed latency earlier
	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("done without matching accept");

	// degenerate flag matches a zero column length
	a_degen_scale: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (degenerate == ((scale_x == 31'd0) || (scale_y == 31'd0) ||
		                         (scale_z == 31'd0))))
		else $error("degenerate does not match scale");

	// degenerate words carry the identity quaternion
	a_degen_ident: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (quat_x == 18'sd0 && quat_y == 18'sd0 &&
		                          quat_z == 18'sd0 && quat_w == 18'sd65536))
		else $error("degenerate word without identity quaternion");

	// quaternion components stay within plus or minus one
	a_quat_rng: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (quat_x >= -18'sd65536 && quat_x <= 18'sd65536 &&
		          quat_y >= -18'sd65536 && quat_y <= 18'sd65536 &&
		          quat_z >= -18'sd65536 && quat_z <= 18'sd65536 &&
		          quat_w >= -18'sd65536 && quat_w <= 18'sd65536))
		else $error("quaternion component out of range");
`endif

endmodule

// ===== hdl/amd_sqrt.sv =====
`timescale 1ns / 1ps

// Integer square root, floor(sqrt(rad)), one root bit per stage.
module amd_sqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           vin,
	input  logic [amd_pkg::SQ_IN_W-1:0]    rad,
	output logic                           vout,
	output logic [amd_pkg::SQ_OUT_W-1:0]   root
);
	import amd_pkg::*;

	logic                vld_s [SQ_LAT];
	logic [SQ_IN_W-1:0]  rem_s [SQ_LAT];
	logic [SQ_IN_W-1:0]  acc_s [SQ_LAT];

	for (genvar t = 0; t < SQ_LAT; t++) begin : g_stage
		localparam logic [SQ_IN_W-1:0] BIT =
			{{(SQ_IN_W-1){1'b0}}, 1'b1} << (SQ_IN_W - 2 - 2 * t);
		logic               prv_v;
		logic [SQ_IN_W-1:0] prv_rem;
		logic [SQ_IN_W-1:0] prv_acc;
		logic [SQ_IN_W-1:0] trial;
		logic               ge;

		if (t == 0) begin : g_first
			assign prv_v   = vin;
			assign prv_rem = rad;
			assign prv_acc = '0;
		end else begin : g_next
			assign prv_v   = vld_s[t-1];
			assign prv_rem = rem_s[t-1];
			assign prv_acc = acc_s[t-1];
		end

		assign trial = prv_acc + BIT;
		assign ge    = (prv_rem >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[t] <= 1'b0;
			end else begin
				vld_s[t] <= prv_v;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[t] <= ge ? (prv_rem - trial) : prv_rem;
			acc_s[t] <= ge ? ((prv_acc >> 1) + BIT) : (prv_acc >> 1);
		end
	end

	assign vout = vld_s[SQ_LAT-1];
	assign root = acc_s[SQ_LAT-1][SQ_OUT_W-1:0];

endmodule

// ===== hdl/amd_div.sv =====
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per stage.
// Caller guarantees the quotient fits in DV_Q_W bits.
module amd_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           vin,
	input  logic [amd_pkg::DV_NUM_W-1:0]   num,
	input  logic [amd_pkg::DV_DEN_W-1:0]   den,
	output logic                           vout,
	output logic [amd_pkg::DV_Q_W-1:0]     quo
);
	import amd_pkg::*;

	logic                 vld_s [DV_LAT];
	logic [DV_NUM_W-1:0]  rem_s [DV_LAT];
	logic [DV_DEN_W-1:0]  den_s [DV_LAT];
	logic [DV_Q_W-1:0]    quo_s [DV_LAT];

	for (genvar t = 0; t < DV_LAT; t++) begin : g_stage
		logic                prv_v;
		logic [DV_NUM_W-1:0] prv_rem;
		logic [DV_DEN_W-1:0] prv_den;
		logic [DV_Q_W-1:0]   prv_quo;
		logic [DV_NUM_W-1:0] dsh;
		logic                ge;

		if (t == 0) begin : g_first
			assign prv_v   = vin;
			assign prv_rem = num;
			assign prv_den = den;
			assign prv_quo = '0;
		end else begin : g_next
			assign prv_v   = vld_s[t-1];
			assign prv_rem = rem_s[t-1];
			assign prv_den = den_s[t-1];
			assign prv_quo = quo_s[t-1];
		end

		assign dsh = {{(DV_NUM_W-DV_DEN_W){1'b0}}, prv_den} << (DV_Q_W - 1 - t);
		assign ge  = (prv_rem >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[t] <= 1'b0;
			end else begin
				vld_s[t] <= prv_v;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[t] <= ge ? (prv_rem - dsh) : prv_rem;
			den_s[t] <= prv_den;
			quo_s[t] <= {prv_quo[DV_Q_W-2:0], ge};
		end
	end

	assign vout = vld_s[DV_LAT-1];
	assign quo  = quo_s[DV_LAT-1];

endmodule
